@@ hdl/gzl_pkg.sv @@
// Shared types, constants and modular helpers of the Zech logarithm ALU.
// Used by the channel interfaces and by every module of the block.
package gzl_pkg;

    localparam int CODE_W         = 8;
    localparam int OP_W           = 3;
    localparam int NEG_W          = 7;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 8;
    localparam int FIELD_SIZE_DEF = 256;

    // The modulo reducer retires two quotient bits per stage.
    localparam int RED_STEPS  = 2;
    localparam int RED_STAGES = CODE_W / RED_STEPS;

    typedef logic [CODE_W-1:0] t_code;

    localparam t_code CODE_ONE = t_code'(1);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GROUP_ORDER = 1'b0,
        CFG_NEG_ONE_LOG = 1'b1
    } t_cfg_idx;

    // Write request into the Zech table.
    typedef struct packed {
        logic  we;
        t_code addr;
        t_code data;
    } t_zech_wr;

    // Sum of two residues below n, reduced modulo n.
    function automatic t_code mod_add(t_code x, t_code y, t_code n);
        logic [CODE_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, n}) begin
            s = s - {1'b0, n};
        end
        return s[CODE_W-1:0];
    endfunction

    // Difference of two residues below n, reduced modulo n.
    function automatic t_code mod_sub(t_code x, t_code y, t_code n);
        t_code d;
        d = x - y;
        if (x < y) begin
            d = d + n;
        end
        return d;
    endfunction

endpackage

@@ hdl/gzl_if.sv @@
// Valid/ready channel interfaces of the Zech logarithm ALU.
// Depends on gzl_pkg for the field widths.
interface gzl_in_if;
    logic                          valid;
    logic                          ready;
    logic [gzl_pkg::OP_W-1:0]      opcode;
    logic [gzl_pkg::CODE_W-1:0]    operand_a;
    logic [gzl_pkg::CODE_W-1:0]    operand_b;
    logic [gzl_pkg::CODE_W-1:0]    table_index;
    logic [gzl_pkg::CODE_W-1:0]    table_value;

    modport source (output valid, opcode, operand_a, operand_b, table_index, table_value,
                    input ready);
    modport sink   (input valid, opcode, operand_a, operand_b, table_index, table_value,
                    output ready);
endinterface

interface gzl_out_if;
    logic                          valid;
    logic                          ready;
    logic [gzl_pkg::CODE_W-1:0]    result_code;
    logic                          divide_by_zero;

    modport source (output valid, result_code, divide_by_zero, input ready);
    modport sink   (input valid, result_code, divide_by_zero, output ready);
endinterface

@@ hdl/gzl_mod_reduce.sv @@
// Pipelined reduction of an element code modulo the group order.
// Restoring remainder, two quotient bits per stage; depends on gzl_pkg.
module gzl_mod_reduce (
    input  logic                          i_clk,
    input  logic [gzl_pkg::RED_STAGES-1:0] i_en,
    input  gzl_pkg::t_code                i_x,
    input  gzl_pkg::t_code                i_n,
    output gzl_pkg::t_code                o_r
);
    import gzl_pkg::*;

    t_code r_rem [RED_STAGES];
    t_code n_rem [RED_STAGES];

    // Each stage subtracts n shifted by its two quotient bit positions.
    always_comb begin
        t_code                 v;
        logic [2*CODE_W-1:0]   sh;
        for (int s = 0; s < RED_STAGES; s++) begin
            v = (s == 0) ? i_x : r_rem[(s == 0) ? 0 : s-1];
            for (int j = 0; j < RED_STEPS; j++) begin
                sh = {{CODE_W{1'b0}}, i_n} << (CODE_W - 1 - (s * RED_STEPS + j));
                if ({{CODE_W{1'b0}}, v} >= sh) begin
                    v = v - sh[CODE_W-1:0];
                end
            end
            n_rem[s] = v;
        end
    end

    // Partial remainders advance with their stage enables.
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < RED_STAGES; s++) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem[s];
            end
        end
    end

    assign o_r = r_rem[RED_STAGES-1];

endmodule

@@ hdl/gzl_zech_ram.sv @@
// Zech table storage: one write port and one registered read port.
// Depends on gzl_pkg for the code type and the write request struct.
module gzl_zech_ram #(
    parameter int DEPTH = gzl_pkg::FIELD_SIZE_DEF - 1
) (
    input  logic              i_clk,
    input  gzl_pkg::t_zech_wr i_wr,
    input  logic              i_rd_en,
    input  gzl_pkg::t_code    i_rd_addr,
    output gzl_pkg::t_code    o_rd_data
);
    import gzl_pkg::*;

    // An 8-bit index reaches at most 2**CODE_W entries.
    localparam int MEM_DEPTH = (DEPTH < 2**CODE_W) ? DEPTH : 2**CODE_W;
    localparam int AW        = $clog2(MEM_DEPTH);

    t_code r_mem [MEM_DEPTH];
    t_code r_rd_data;

    // Write and read in one clocked block; a read of an entry written at the same edge returns its old value.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/gf_zech_log_alu.sv @@
// Top level of the Zech logarithm ALU: twelve-stage pipeline, config registers.
// Depends on gzl_pkg, gzl_if, gzl_mod_reduce and gzl_zech_ram.
//
// Usage: elements travel as codes, 0 for zero and k for alpha^(k-1). A beat on
// i_in carries an opcode (load Zech entry, add, subtract, multiply, divide),
// two operands and a table index and value for loads. Every input beat yields
// exactly one beat on o_out with the result code and a divide-by-zero flag.
// Registers group_order and neg_one_log are written on the plain write port
// (i_cfg_we, i_cfg_idx, i_cfg_data); the user must write them only while the
// pipeline is empty, as the block itself does not enforce it. The block takes
// one beat per cycle while the receiver is ready or some stage is empty. The
// stage count is set by two four-stage modulo reducers (operand logs, then the
// log of the Zech entry) around the registered table read; loads write the
// table at the read stage, so every later operation sees them.
// Synchronous reset clears the stage valid bits and sets group_order to 255
// and neg_one_log to 0; the table holds nothing until loaded.
// When the receiver stalls, stages fill up behind the output register; input
// is still taken while any stage holds a bubble, and nothing is lost.
module gf_zech_log_alu #(
    parameter int FIELD_SIZE = gzl_pkg::FIELD_SIZE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    gzl_in_if.sink                          i_in,
    gzl_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [gzl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gzl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import gzl_pkg::*;

    localparam int TABLE_DEPTH = FIELD_SIZE - 1;
    localparam int NS          = 12;
    localparam int ST_MID      = RED_STAGES;
    localparam int ST_DIFF     = RED_STAGES + 1;
    localparam int ST_READ     = RED_STAGES + 2;
    localparam int ST_ZRED     = RED_STAGES + 3;
    localparam int ST_OUT      = NS - 1;

    typedef struct packed {
        t_op   op;
        logic  az;
        logic  bz;
        t_code ti;
        t_code tv;
    } t_side;

    typedef struct packed {
        t_side side;
        t_code la;
        t_code lb;
        t_code nb;
        t_code prod;
        t_code quo;
    } t_mid;

    typedef struct packed {
        t_side side;
        t_code la;
        t_code lbe;
        t_code d;
        t_code prod;
        t_code quo;
    } t_diff;

    typedef struct packed {
        t_op   op;
        logic  az;
        logic  bz;
        logic  zz;
        t_code la;
        t_code lbe;
        t_code prod;
        t_code quo;
    } t_tail;

    // Configuration registers.
    t_code            r_group_order;
    logic [NEG_W-1:0] r_neg_one_log;
    t_code            w_ord;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_order <= t_code'(255);
            r_neg_one_log <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GROUP_ORDER: begin
                    r_group_order <= i_cfg_data[CODE_W-1:0];
                end
                CFG_NEG_ONE_LOG: begin
                    r_neg_one_log <= i_cfg_data[NEG_W-1:0];
                end
            endcase
        end
    end

    // A zero group order behaves as one.
    assign w_ord = (r_group_order == '0) ? CODE_ONE : r_group_order;

    // Stage enables: a stage loads when empty or when the next one moves.
    logic [NS-1:0] r_vld;
    logic [NS:0]   w_en;

    always_comb begin
        w_en[NS] = o_out.ready;
        for (int s = NS - 1; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // Stages 0 to 3: reduce the operand logs and the log of minus one.
    t_side w_side_in;
    t_side r_side [RED_STAGES];
    t_code w_la;
    t_code w_lb;
    t_code w_lng;

    assign w_side_in = '{op: t_op'(i_in.opcode),
                         az: (i_in.operand_a == '0),
                         bz: (i_in.operand_b == '0),
                         ti: i_in.table_index,
                         tv: i_in.table_value};

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side[0] <= w_side_in;
        end
        for (int s = 1; s < RED_STAGES; s++) begin
            if (w_en[s]) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    gzl_mod_reduce u_red_a (
        .i_clk (i_clk),
        .i_en  (w_en[RED_STAGES-1:0]),
        .i_x   (i_in.operand_a - CODE_ONE),
        .i_n   (w_ord),
        .o_r   (w_la)
    );

    gzl_mod_reduce u_red_b (
        .i_clk (i_clk),
        .i_en  (w_en[RED_STAGES-1:0]),
        .i_x   (i_in.operand_b - CODE_ONE),
        .i_n   (w_ord),
        .o_r   (w_lb)
    );

    gzl_mod_reduce u_red_neg (
        .i_clk (i_clk),
        .i_en  (w_en[RED_STAGES-1:0]),
        .i_x   ({1'b0, r_neg_one_log}),
        .i_n   (w_ord),
        .o_r   (w_lng)
    );

    // Stage 4: log of minus operand b, product and quotient logs.
    t_mid r_mid;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_MID]) begin
            r_mid <= '{side: r_side[RED_STAGES-1],
                       la:   w_la,
                       lb:   w_lb,
                       nb:   mod_add(w_lb, w_lng, w_ord),
                       prod: mod_add(w_la, w_lb, w_ord),
                       quo:  mod_sub(w_la, w_lb, w_ord)};
        end
    end

    // Stage 5: pick the second log for the sum and form the Zech exponent.
    t_diff r_diff;
    t_code w_lbe;

    assign w_lbe = (r_mid.side.op == OP_SUB) ? r_mid.nb : r_mid.lb;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_DIFF]) begin
            r_diff <= '{side: r_mid.side,
                        la:   r_mid.la,
                        lbe:  w_lbe,
                        d:    mod_sub(r_mid.la, w_lbe, w_ord),
                        prod: r_mid.prod,
                        quo:  r_mid.quo};
        end
    end

    // Stage 6: table read, and the table write of a load beat.
    t_zech_wr w_wr;
    t_code    w_zraw;
    t_tail    r_rd;

    assign w_wr = '{we:   w_en[ST_READ] && r_vld[ST_DIFF] && (r_diff.side.op == OP_LOAD)
                          && (32'(r_diff.side.ti) < TABLE_DEPTH),
                    addr: r_diff.side.ti,
                    data: r_diff.side.tv};

    gzl_zech_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_en   (w_en[ST_READ]),
        .i_rd_addr (r_diff.d),
        .o_rd_data (w_zraw)
    );

    // An exponent past the table reads as a zero entry.
    always_ff @(posedge i_clk) begin
        if (w_en[ST_READ]) begin
            r_rd <= '{op:   r_diff.side.op,
                      az:   r_diff.side.az,
                      bz:   r_diff.side.bz,
                      zz:   !(32'(r_diff.d) < TABLE_DEPTH),
                      la:   r_diff.la,
                      lbe:  r_diff.lbe,
                      prod: r_diff.prod,
                      quo:  r_diff.quo};
        end
    end

    // Stages 7 to 10: reduce the log of the Zech entry.
    t_tail w_tail_in;
    t_tail r_tail [RED_STAGES];
    t_code w_lz;

    always_comb begin
        w_tail_in    = r_rd;
        w_tail_in.zz = r_rd.zz || (w_zraw == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_ZRED]) begin
            r_tail[0] <= w_tail_in;
        end
        for (int s = 1; s < RED_STAGES; s++) begin
            if (w_en[ST_ZRED+s]) begin
                r_tail[s] <= r_tail[s-1];
            end
        end
    end

    gzl_mod_reduce u_red_z (
        .i_clk (i_clk),
        .i_en  (w_en[ST_ZRED+RED_STAGES-1:ST_ZRED]),
        .i_x   (w_zraw - CODE_ONE),
        .i_n   (w_ord),
        .o_r   (w_lz)
    );

    // Stage 11: select the result by opcode into the output register.
    t_tail w_tl;
    t_code w_zsum;
    t_code n_res;
    logic  n_dz;
    t_code r_res;
    logic  r_dz;

    assign w_tl   = r_tail[RED_STAGES-1];
    assign w_zsum = mod_add(w_tl.lbe, w_lz, w_ord) + CODE_ONE;

    always_comb begin
        n_res = '0;
        n_dz  = 1'b0;
        unique case (w_tl.op) inside
            OP_ADD, OP_SUB: begin
                if (w_tl.bz) begin
                    n_res = w_tl.az ? '0 : w_tl.la + CODE_ONE;
                end else if (w_tl.az) begin
                    n_res = w_tl.lbe + CODE_ONE;
                end else begin
                    n_res = w_tl.zz ? '0 : w_zsum;
                end
            end
            OP_MUL: begin
                n_res = (w_tl.az || w_tl.bz) ? '0 : w_tl.prod + CODE_ONE;
            end
            OP_DIV: begin
                if (w_tl.bz) begin
                    n_dz = 1'b1;
                end else if (!w_tl.az) begin
                    n_res = w_tl.quo + CODE_ONE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            r_res <= n_res;
            r_dz  <= n_dz;
        end
    end

    assign o_out.valid          = r_vld[ST_OUT];
    assign o_out.result_code    = r_res;
    assign o_out.divide_by_zero = r_dz;

    // A flagged divide never carries a nonzero code.
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.divide_by_zero) |-> (o_out.result_code == '0))
        else $error("divide by zero beat with nonzero result code");

    // With every stage full and the receiver stalled, no input beat is taken.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while the pipeline is full and stalled");

    // Result codes never name a log at or above the group order.
    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.result_code <= w_ord))
        else $error("result code beyond the group order");

endmodule
